FILE: design/k_group_block_reverser_macros.svh
// Assertion macros shared by the k-group block reverser modules.
`ifndef K_GROUP_BLOCK_REVERSER_MACROS_SVH
`define K_GROUP_BLOCK_REVERSER_MACROS_SVH

`ifndef SYNTHESIS
`define KGBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KGBR_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define KGBR_ASSERT(lbl, prop, msg)
`define KGBR_NEVER(lbl, expr, msg)
`endif

`endif

FILE: design/kgbr_pkg.sv
// Shared types and constants of the k-group block reverser.
`default_nettype none
package kgbr_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;
  localparam int APB_AW = 3;

  // Register map
  localparam logic [APB_AW-1:0] ADDR_GROUP_SIZE  = 3'd0;
  localparam logic [CFG_W-1:0]  GROUP_SIZE_RESET = 5'd1;

  // How a finished group is to be replayed
  typedef struct packed {
    logic reverse;  // newest first
    logic eos;      // group closes the sequence
  } grp_flags_t;

endpackage
`default_nettype wire

FILE: design/kgbr_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module kgbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/kgbr_front.sv
// Input side: stores elements into the write bank and closes groups.
`default_nettype none
module kgbr_front import kgbr_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [CNT_W-1:0]        k_eff,
  input  wire logic                    s_axis_tvalid,
  output      logic                    s_axis_tready,
  input  wire logic signed [DATA_W-1:0] s_axis_tdata,   // element_value
  input  wire logic                    s_axis_tlast,   // end_of_sequence
  input  wire logic                    q_full,
  input  wire logic                    wbank,
  output      logic                    ram_we,
  output      logic [IDX_W:0]          ram_waddr,
  output      logic [DATA_W-1:0]       ram_wdata,
  output      logic                    q_push,
  output      logic [CNT_W-1:0]        q_push_count,
  output      grp_flags_t              q_push_flags
);

  logic [IDX_W-1:0] fill;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             reach;
  logic             emit;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign count         = CNT_W'(fill) + CNT_W'(1);
  assign reach         = (count >= k_eff);
  assign emit          = reach || s_axis_tlast;

  assign ram_we    = accept;
  assign ram_waddr = {wbank, fill};
  assign ram_wdata = s_axis_tdata;

  assign q_push               = accept && emit;
  assign q_push_count         = count;
  assign q_push_flags.reverse = reach;
  assign q_push_flags.eos     = s_axis_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= emit ? '0 : fill + 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: design/kgbr_queue.sv
// Two-slot group descriptor queue; slot i owns RAM bank i.
`default_nettype none
module kgbr_queue import kgbr_pkg::*; #(
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [CNT_W-1:0] push_count,
  input  wire grp_flags_t       push_flags,
  output      logic             full,
  output      logic             wbank,
  input  wire logic             pop,
  output      logic             head_valid,
  output      logic [CNT_W-1:0] head_count,
  output      grp_flags_t       head_flags,
  output      logic             rbank
);

  logic             busy [2];
  logic [CNT_W-1:0] cnt  [2];
  grp_flags_t       flg  [2];
  logic             wptr;
  logic             rptr;

  assign full       = busy[wptr];
  assign wbank      = wptr;
  assign head_valid = busy[rptr];
  assign head_count = cnt[rptr];
  assign head_flags = flg[rptr];
  assign rbank      = rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy[0] <= 1'b0;
      busy[1] <= 1'b0;
      wptr    <= 1'b0;
      rptr    <= 1'b0;
    end else begin
      if (push) begin
        busy[wptr] <= 1'b1;
        wptr       <= ~wptr;
      end
      if (pop) begin
        busy[rptr] <= 1'b0;
        rptr       <= ~rptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cnt[wptr] <= push_count;
      flg[wptr] <= push_flags;
    end
  end

  `include "k_group_block_reverser_macros.svh"

  `KGBR_ASSERT(a_push_free, push |-> !busy[wptr], "group pushed into an occupied bank")
  `KGBR_ASSERT(a_pop_valid, pop |-> busy[rptr], "group released from an empty bank")

endmodule
`default_nettype wire

FILE: design/kgbr_back.sv
// Output side: replays one group from its bank through a two-entry skid queue.
`default_nettype none
module kgbr_back import kgbr_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     head_valid,
  input  wire logic [CNT_W-1:0]         head_count,
  input  wire grp_flags_t               head_flags,
  input  wire logic                     rbank,
  output      logic                     q_pop,
  output      logic                     ram_re,
  output      logic [IDX_W:0]           ram_raddr,
  input  wire logic [DATA_W-1:0]        ram_rdata,
  output      logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output      logic signed [DATA_W-1:0] m_axis_tdata,   // out_value
  output      logic                     m_axis_tlast,   // run_last
  output      logic [0:0]               m_axis_tuser    // out_end_of_sequence
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cur_count;
  grp_flags_t       cur_flags;
  logic             pend;
  logic             pend_last;
  logic             pend_eos;

  logic [DATA_W-1:0] f_data [2];
  logic              f_last [2];
  logic              f_eos  [2];
  logic              head;
  logic [1:0]        occ;

  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] src;
  logic             last_i;
  logic             out_pop;
  logic [2:0]       occ_next;
  logic             issue;

  assign idx_ext  = CNT_W'(idx);
  assign last_i   = (CNT_W'(idx_ext + CNT_W'(1)) == cur_count);
  assign src      = cur_flags.reverse ? CNT_W'(cur_count - CNT_W'(1) - idx_ext) : idx_ext;
  assign out_pop  = m_axis_tvalid && m_axis_tready;
  // occupancy once the read in flight has landed and this cycle's pop is gone
  assign occ_next = 3'(occ) + 3'(pend) - 3'(out_pop);
  assign issue    = (state == RUN) && (occ_next < 3'd2);

  assign ram_re    = issue;
  assign ram_raddr = {rbank, src[IDX_W-1:0]};
  assign q_pop     = issue && last_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx   <= '0;
      pend  <= 1'b0;
    end else begin
      pend <= issue;
      case (state)
        IDLE: begin
          if (head_valid) begin
            idx   <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          if (issue) begin
            if (last_i) begin
              state <= IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
    if (state == IDLE) begin
      cur_count <= head_count;
      cur_flags <= head_flags;
    end
    pend_last <= last_i;
    pend_eos  <= last_i && cur_flags.eos;
  end

  // skid queue
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      occ  <= 2'd0;
    end else begin
      occ <= occ_next[1:0];
      if (out_pop) begin
        head <= ~head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      f_data[head ^ occ[0]] <= ram_rdata;
      f_last[head ^ occ[0]] <= pend_last;
      f_eos[head ^ occ[0]]  <= pend_eos;
    end
  end

  assign m_axis_tvalid   = (occ != 2'd0);
  assign m_axis_tdata    = f_data[head];
  assign m_axis_tlast    = f_last[head];
  assign m_axis_tuser[0] = f_eos[head];

  `include "k_group_block_reverser_macros.svh"

  `KGBR_ASSERT(a_skid_room, pend |-> (occ != 2'd2), "read data lands on a full skid queue")
  `KGBR_NEVER(a_occ_range, occ == 2'd3, "skid queue occupancy out of range")

endmodule
`default_nettype wire

FILE: design/k_group_block_reverser.sv
// Top level of the k-group block reverser: register port and the front/back pair.
//
// Elements stream in on s_axis (tdata = element_value, tlast = end_of_sequence)
// and are written into one of two RAM banks. When group_size elements have
// gathered, the group is handed to the output side and replayed newest first;
// if the sequence ends short of a full group, the partial group is replayed in
// arrival order. Results leave on m_axis with tlast on the last result caused
// by an input item and tuser[0] on the final result of the sequence.
// group_size 0 acts as 1 (pass through); values above MAX_GROUP act as
// MAX_GROUP. Write group_size only while the block is idle.
// Rate: the input takes one item per cycle while a bank is free; the output
// gives one result per cycle while m_axis_tready is high, apart from a pass
// through the idle state at the start of each group. The two banks let one
// group fill while the other drains; the input stalls only when both hold
// finished groups.
`default_nettype none
module k_group_block_reverser import kgbr_pkg::*; #(
  parameter int MAX_GROUP = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // APB register port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_AW-1:0]        paddr,
  input  wire logic [31:0]              pwdata,
  output      logic [31:0]              prdata,
  output      logic                     pready,
  // input items
  input  wire logic                     s_axis_tvalid,
  output      logic                     s_axis_tready,
  input  wire logic signed [DATA_W-1:0] s_axis_tdata,   // element_value
  input  wire logic                     s_axis_tlast,   // end_of_sequence
  // result items
  output      logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output      logic signed [DATA_W-1:0] m_axis_tdata,   // out_value
  output      logic                     m_axis_tlast,   // run_last
  output      logic [0:0]               m_axis_tuser    // out_end_of_sequence
);

  localparam int IDX_W     = $clog2(MAX_GROUP);
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RAM_DEPTH = 2 ** (IDX_W + 1);   // two banks

  logic [CFG_W-1:0] group_size;
  logic [CMP_W-1:0] gs_ext;
  logic [CNT_W-1:0] k_eff;
  logic             cfg_wr;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_GROUP_SIZE);
  assign prdata = (paddr == ADDR_GROUP_SIZE) ? 32'(group_size) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GROUP_SIZE_RESET;
    end else if (cfg_wr) begin
      group_size <= pwdata[CFG_W-1:0];
    end
  end

  // group size in force, clamped to 1..MAX_GROUP
  assign gs_ext = CMP_W'(group_size);
  always_comb begin
    if (gs_ext == '0) begin
      k_eff = CNT_W'(1);
    end else if (gs_ext > CMP_W'(MAX_GROUP)) begin
      k_eff = CNT_W'(MAX_GROUP);
    end else begin
      k_eff = gs_ext[CNT_W-1:0];
    end
  end

  // front <-> queue <-> back
  logic              q_push;
  logic [CNT_W-1:0]  q_push_count;
  grp_flags_t        q_push_flags;
  logic              q_full;
  logic              wbank;
  logic              q_pop;
  logic              head_valid;
  logic [CNT_W-1:0]  head_count;
  grp_flags_t        head_flags;
  logic              rbank;

  logic              ram_we;
  logic [IDX_W:0]    ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W:0]    ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  kgbr_front #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .k_eff         (k_eff),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .wbank         (wbank),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .q_push        (q_push),
    .q_push_count  (q_push_count),
    .q_push_flags  (q_push_flags)
  );

  kgbr_queue #(
    .CNT_W (CNT_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_count (q_push_count),
    .push_flags (q_push_flags),
    .full       (q_full),
    .wbank      (wbank),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_count (head_count),
    .head_flags (head_flags),
    .rbank      (rbank)
  );

  kgbr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kgbr_back #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_count    (head_count),
    .head_flags    (head_flags),
    .rbank         (rbank),
    .q_pop         (q_pop),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire
